// ===== src/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, codes and helpers of the segmented frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int PAY_BYTES   = FRAME_BYTES - 1;

  // configuration register indexes
  localparam logic [2:0] CFG_SOURCE_ID    = 3'd0;
  localparam logic [2:0] CFG_BLOCK_SIZE   = 3'd1;
  localparam logic [2:0] CFG_FLOW_STATUS  = 3'd2;
  localparam logic [2:0] CFG_SEP_TIME     = 3'd3;
  localparam logic [2:0] CFG_CF_TIMEOUT   = 3'd4;
  localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd5;

  // protocol control nibbles
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;
  localparam logic [3:0] PCI_FC = 4'h3;

  localparam logic [3:0] FC_CTL_HI = 4'h3;
  localparam logic [7:0] ST_MAX    = 8'h7F;
  localparam logic [7:0] ST_US_LO  = 8'hF1;
  localparam logic [7:0] ST_US_HI  = 8'hF9;

  localparam logic [31:0] CF_TIMEOUT_RST = 32'd250000;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FC   = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_SEQ     = 3'd1,
    ERR_LATE_CF = 3'd2,
    ERR_TYPE    = 3'd3,
    ERR_IDLE    = 3'd4
  } err_code_t;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_FC   = 2'd1,
    TAIL_DONE = 2'd2,
    TAIL_ERR  = 2'd3
  } tail_t;

  typedef struct packed {
    logic [28:0] source_id;
    logic [7:0]  block_size;
    logic [3:0]  flow_status;
    logic [7:0]  sep_time;
    logic [31:0] cf_timeout;
    logic [31:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic                        mode;
    logic [28:0]                 frame_id;
    logic [3:0]                  frame_length;
    logic [FRAME_BYTES-1:0][7:0] bytes;
  } item_t;

  // all results of one item: payload bytes, then an optional closing result
  typedef struct packed {
    logic [2:0]                nbytes;
    tail_t                     tail;
    logic [PAY_BYTES-1:0][7:0] data;
    logic [11:0]               base_off;
    logic [11:0]               msg_len;
    logic [7:0]                fc_ctl;
    logic [7:0]                fc_bs;
    logic [7:0]                fc_st;
    err_code_t                 err;
  } batch_t;

  // reserved separation times go out as the longest millisecond value
  function automatic logic [7:0] sep_fix(input logic [7:0] st);
    logic [7:0] r;
    r = st;
    if (st > ST_MAX && (st < ST_US_LO || st > ST_US_HI)) r = ST_MAX;
    return r;
  endfunction

endpackage

// ===== src/sfr_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_step
// Protocol state and per-item decode: turns one item into a result batch.
// ----------------------------------------------------------------------------
module sfr_step import sfr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   go,
  input  item_t  itm,
  output batch_t bat
);

  logic        rcv_r,  rcv_nxt;
  logic [3:0]  seq_r,  seq_nxt;
  logic [11:0] rem_r,  rem_nxt;
  logic [11:0] wo_r,   wo_nxt;
  logic [11:0] tot_r,  tot_nxt;
  logic [7:0]  bl_r,   bl_nxt;
  logic [31:0] gap_r,  gap_nxt;
  logic [31:0] idle_r, idle_nxt;

  logic [3:0]  pci;
  logic [2:0]  sf_len;
  logic [11:0] ff_len;
  logic [31:0] idle_inc;
  logic [7:0]  bl_dec;
  logic        to_idle;

  always_comb begin
    rcv_nxt  = rcv_r;
    seq_nxt  = seq_r;
    rem_nxt  = rem_r;
    wo_nxt   = wo_r;
    tot_nxt  = tot_r;
    bl_nxt   = bl_r;
    gap_nxt  = gap_r;
    idle_nxt = idle_r;
    to_idle  = 1'b0;

    bat      = '0;
    bat.tail = TAIL_NONE;
    bat.err  = ERR_NONE;
    bat.fc_ctl = {FC_CTL_HI, cfg.flow_status};
    bat.fc_bs  = cfg.block_size;
    bat.fc_st  = sep_fix(cfg.sep_time);

    pci      = itm.bytes[0][7:4];
    sf_len   = (itm.bytes[0][3:0] > 4'd7) ? 3'd7 : itm.bytes[0][2:0];
    ff_len   = {itm.bytes[0][3:0], itm.bytes[1]};
    idle_inc = (idle_r == '1) ? idle_r : idle_r + 32'd1;
    bl_dec   = bl_r - 8'd1;

    if (go) begin
      if (itm.mode) begin
        if (rcv_r) begin
          idle_nxt = '0;
          if (gap_r != '1) gap_nxt = gap_r + 32'd1;
        end else begin
          idle_nxt = idle_inc;
          if (cfg.idle_timeout != '1 && idle_inc > cfg.idle_timeout) begin
            bat.tail = TAIL_ERR;
            bat.err  = ERR_IDLE;
            to_idle  = 1'b1;
          end
        end
      end else if (itm.frame_id == cfg.source_id && itm.frame_length != 4'd0) begin
        idle_nxt = '0;
        case (pci)
          PCI_SF: begin
            for (int i = 0; i < PAY_BYTES; i++) bat.data[i] = itm.bytes[i+1];
            bat.nbytes  = sf_len;
            bat.msg_len = {9'd0, sf_len};
            bat.tail    = TAIL_DONE;
            tot_nxt     = {9'd0, sf_len};
            wo_nxt      = {9'd0, sf_len};
            to_idle     = 1'b1;
          end
          PCI_FF: begin
            if (ff_len > 12'd6) begin
              for (int i = 0; i < PAY_BYTES - 1; i++) bat.data[i] = itm.bytes[i+2];
              bat.nbytes  = 3'd6;
              bat.msg_len = ff_len;
              bat.tail    = TAIL_FC;
              rcv_nxt     = 1'b1;
              seq_nxt     = 4'd1;
              tot_nxt     = ff_len;
              rem_nxt     = ff_len - 12'd6;
              wo_nxt      = 12'd6;
              bl_nxt      = cfg.block_size;
              gap_nxt     = '0;
            end
          end
          PCI_CF: begin
            if (rcv_r) begin
              if (gap_r > cfg.cf_timeout) begin
                bat.tail = TAIL_ERR;
                bat.err  = ERR_LATE_CF;
                to_idle  = 1'b1;
              end else if (itm.bytes[0][3:0] != seq_r) begin
                bat.tail = TAIL_ERR;
                bat.err  = ERR_SEQ;
                to_idle  = 1'b1;
              end else begin
                for (int i = 0; i < PAY_BYTES; i++) bat.data[i] = itm.bytes[i+1];
                bat.base_off = wo_r;
                bat.msg_len  = tot_r;
                gap_nxt      = '0;
                wo_nxt       = wo_r + 12'd7;
                if (rem_r <= 12'd7) begin
                  bat.nbytes = rem_r[2:0];
                  bat.tail   = TAIL_DONE;
                  to_idle    = 1'b1;
                end else begin
                  bat.nbytes = 3'd7;
                  rem_nxt    = rem_r - 12'd7;
                  seq_nxt    = seq_r + 4'd1;
                  if (cfg.block_size != 8'd0) begin
                    bl_nxt = bl_dec;
                    // block done: reload and ask for the next block
                    if (bl_dec == 8'd0) begin
                      bl_nxt   = cfg.block_size;
                      bat.tail = TAIL_FC;
                    end
                  end
                end
              end
            end
          end
          PCI_FC: begin
            // flow control is not taken on the receive side: drop
          end
          default: begin
            bat.tail = TAIL_ERR;
            bat.err  = ERR_TYPE;
            to_idle  = 1'b1;
          end
        endcase
      end
    end

    if (to_idle) begin
      rcv_nxt  = 1'b0;
      seq_nxt  = 4'd1;
      rem_nxt  = '0;
      idle_nxt = '0;
      gap_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rcv_r  <= 1'b0;
      seq_r  <= 4'd1;
      rem_r  <= '0;
      wo_r   <= '0;
      tot_r  <= '0;
      bl_r   <= 8'd1;
      gap_r  <= '0;
      idle_r <= '0;
    end else begin
      rcv_r  <= rcv_nxt;
      seq_r  <= seq_nxt;
      rem_r  <= rem_nxt;
      wo_r   <= wo_nxt;
      tot_r  <= tot_nxt;
      bl_r   <= bl_nxt;
      gap_r  <= gap_nxt;
      idle_r <= idle_nxt;
    end
  end

endmodule

// ===== src/sfr_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_emit
// Result register: holds one batch and sends its results one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sfr_emit import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  batch_t      bat_in,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic [11:0] out_byte_offset,
  output logic [11:0] out_message_length,
  output logic [7:0]  out_fc_control,
  output logic [7:0]  out_fc_block_size,
  output logic [7:0]  out_fc_sep_time,
  output logic [2:0]  out_fault_code,
  output logic        out_last
);

  logic       vld_r, vld_nxt;
  batch_t     bat_r, bat_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic has_tail, in_bytes, last, pop, has_res;

  assign has_tail = bat_r.tail != TAIL_NONE;
  assign in_bytes = idx_r < bat_r.nbytes;
  assign last     = has_tail ? (idx_r == bat_r.nbytes) : (idx_r == bat_r.nbytes - 3'd1);
  assign pop      = vld_r && !out_stall;
  assign free     = !vld_r || (pop && last);
  assign has_res  = bat_in.nbytes != 3'd0 || bat_in.tail != TAIL_NONE;

  always_comb begin
    vld_nxt = vld_r;
    bat_nxt = bat_r;
    idx_nxt = idx_r;
    if (load && has_res) begin
      vld_nxt = 1'b1;
      bat_nxt = bat_in;
      idx_nxt = '0;
    end else if (pop) begin
      if (last) vld_nxt = 1'b0;
      else      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
    bat_r <= bat_nxt;
  end

  always_comb begin
    out_result_kind    = KIND_DATA;
    out_data_byte      = '0;
    out_byte_offset    = '0;
    out_message_length = '0;
    out_fc_control     = '0;
    out_fc_block_size  = '0;
    out_fc_sep_time    = '0;
    out_fault_code     = ERR_NONE;
    if (in_bytes) begin
      out_result_kind    = KIND_DATA;
      out_data_byte      = bat_r.data[idx_r];
      out_byte_offset    = bat_r.base_off + {9'd0, idx_r};
      out_message_length = bat_r.msg_len;
    end else begin
      case (bat_r.tail)
        TAIL_FC: begin
          out_result_kind   = KIND_FC;
          out_fc_control    = bat_r.fc_ctl;
          out_fc_block_size = bat_r.fc_bs;
          out_fc_sep_time   = bat_r.fc_st;
        end
        TAIL_DONE: begin
          out_result_kind    = KIND_DONE;
          out_message_length = bat_r.msg_len;
        end
        TAIL_ERR: begin
          out_result_kind = KIND_ERR;
          out_fault_code  = bat_r.err;
        end
        default: out_result_kind = KIND_DATA;
      endcase
    end
  end

  assign out_valid = vld_r;
  assign out_last  = last;

endmodule

// ===== src/segmented_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_frame_receiver
// Receive side of a segmented CAN transport layer with flow control.
// ----------------------------------------------------------------------------
//  port group | direction | handshake          | moves
//  in_        | in        | in_valid/in_stall  | one frame or one tick per item
//  out_       | out       | out_valid/out_stall| one result each, last marks an item's end
//  cfg_       | in        | cfg_we             | one register write
//
// An item waits in the input register and is decoded in the cycle it moves to
// the result register. Its results then leave one per cycle while out_stall is
// low, so the result count of an item sets the rate, while items with no result
// or a single result pass every cycle. A new item enters while the last result
// of the previous one is taken. Reset is synchronous and active low.
// out_stall holds the current result; in_stall rises only while the result
// register still has results left to send.
// ----------------------------------------------------------------------------
module segmented_frame_receiver import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [28:0] in_frame_id,
  input  logic [3:0]  in_frame_length,
  input  logic [7:0]  in_byte_0,
  input  logic [7:0]  in_byte_1,
  input  logic [7:0]  in_byte_2,
  input  logic [7:0]  in_byte_3,
  input  logic [7:0]  in_byte_4,
  input  logic [7:0]  in_byte_5,
  input  logic [7:0]  in_byte_6,
  input  logic [7:0]  in_byte_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_data_byte,
  output logic [11:0] out_byte_offset,
  output logic [11:0] out_message_length,
  output logic [7:0]  out_fc_control,
  output logic [7:0]  out_fc_block_size,
  output logic [7:0]  out_fc_sep_time,
  output logic [2:0]  out_fault_code,
  output logic        out_last
);

  cfg_t   cfg_r, cfg_nxt;
  item_t  itm_r, itm_nxt;
  logic   in_vld_r, in_vld_nxt;
  logic   free, go;
  batch_t bat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SOURCE_ID:    cfg_nxt.source_id    = cfg_wdata[28:0];
        CFG_BLOCK_SIZE:   cfg_nxt.block_size   = cfg_wdata[7:0];
        CFG_FLOW_STATUS:  cfg_nxt.flow_status  = cfg_wdata[3:0];
        CFG_SEP_TIME:     cfg_nxt.sep_time     = cfg_wdata[7:0];
        CFG_CF_TIMEOUT:   cfg_nxt.cf_timeout   = cfg_wdata;
        CFG_IDLE_TIMEOUT: cfg_nxt.idle_timeout = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  assign in_stall = in_vld_r && !free;
  assign go       = in_vld_r && free;

  always_comb begin
    in_vld_nxt = in_vld_r;
    itm_nxt    = itm_r;
    if (!in_stall) begin
      in_vld_nxt = in_valid;
      if (in_valid) begin
        itm_nxt.mode         = in_mode;
        itm_nxt.frame_id     = in_frame_id;
        itm_nxt.frame_length = in_frame_length;
        itm_nxt.bytes        = {in_byte_7, in_byte_6, in_byte_5, in_byte_4,
                                in_byte_3, in_byte_2, in_byte_1, in_byte_0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_id    <= '0;
      cfg_r.block_size   <= 8'd1;
      cfg_r.flow_status  <= '0;
      cfg_r.sep_time     <= '0;
      cfg_r.cf_timeout   <= CF_TIMEOUT_RST;
      cfg_r.idle_timeout <= '1;
      in_vld_r           <= 1'b0;
    end else begin
      cfg_r    <= cfg_nxt;
      in_vld_r <= in_vld_nxt;
    end
    itm_r <= itm_nxt;
  end

  sfr_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .go    (go),
    .itm   (itm_r),
    .bat   (bat)
  );

  sfr_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (go),
    .bat_in             (bat),
    .free               (free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_data_byte      (out_data_byte),
    .out_byte_offset    (out_byte_offset),
    .out_message_length (out_message_length),
    .out_fc_control     (out_fc_control),
    .out_fc_block_size  (out_fc_block_size),
    .out_fc_sep_time    (out_fc_sep_time),
    .out_fault_code     (out_fault_code),
    .out_last           (out_last)
  );

  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last && !go) |=> !out_valid)
    else $error("results continue past the last one");

  a_batch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("batch dropped before its last result");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_ERR) |-> out_fault_code != ERR_NONE)
    else $error("error result without error code");

endmodule

// ===== test/segmented_frame_receiver_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_frame_receiver_test
// Self-checking bench for the segmented frame receiver. A clocked driver
// offers frames and ticks from a backlog in random bursts. An in-bench
// transport model predicts payload bytes, flow-control frames, completions
// and errors for every accepted item. A monitor compares each result, field by
// field, while the result side stalls on its own pattern. Register settings
// change between phases and cover their extremes.
// ----------------------------------------------------------------------------
module segmented_frame_receiver_test;
  import sfr_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TICKS = 16;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [11:0] off;
    logic [11:0] len;
    logic [7:0]  ctl;
    logic [7:0]  bs;
    logic [7:0]  st;
    err_code_t   err;
    logic        last;
  } res_t;

  typedef struct {
    item_t frame;
    bit    drain;
  } backlog_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [28:0] in_frame_id = '0;
  logic [3:0]  in_frame_length = '0;
  logic [7:0]  in_byte_0 = '0, in_byte_1 = '0, in_byte_2 = '0, in_byte_3 = '0;
  logic [7:0]  in_byte_4 = '0, in_byte_5 = '0, in_byte_6 = '0, in_byte_7 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_data_byte;
  logic [11:0] out_byte_offset;
  logic [11:0] out_message_length;
  logic [7:0]  out_fc_control;
  logic [7:0]  out_fc_block_size;
  logic [7:0]  out_fc_sep_time;
  logic [2:0]  out_fault_code;
  logic        out_last;

  segmented_frame_receiver dut (.*);

  // transport model: register copy and reassembly state
  cfg_t        rx_cfg = '{source_id: '0, block_size: 8'd1, flow_status: '0, sep_time: '0,
                          cf_timeout: CF_TIMEOUT_RST, idle_timeout: '1};
  logic        rx_active = 1'b0;
  logic [3:0]  seq_want = 4'd1;
  logic [11:0] bytes_left = '0;
  logic [11:0] wr_off = '0;
  logic [11:0] msg_total = '0;
  logic [7:0]  blk_left = 8'd1;
  logic [31:0] gap_cnt = '0;
  logic [31:0] idle_cnt = '0;

  res_t        rx_results_due[$];
  backlog_t    frame_backlog[$];
  item_t       offered;
  backlog_t    next_up;
  res_t        front_res;
  bit          pause_next = 1'b0;
  bit          go_now;
  int          queued_count = 0;
  int          results_owed = 0;
  int          results_taken = 0;
  int          fail_count = 0;
  int          frames_sent = 0, ticks_sent = 0;
  int          kind_count[4] = '{0, 0, 0, 0};
  int          burst_left = 0, gap_left = 0;
  int          hold_req = 0, hold_done = 0, hold_cnt = 0;
  int          stall_style = 0, style_cnt = 0;
  int          cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- model ----------------

  function automatic res_t pay_res(logic [7:0] data, logic [11:0] off, logic [11:0] len);
    res_t r;
    r = '0;
    r.kind = KIND_DATA;
    r.data = data;
    r.off  = off;
    r.len  = len;
    return r;
  endfunction

  function automatic res_t done_res(logic [11:0] len);
    res_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.len  = len;
    return r;
  endfunction

  function automatic res_t err_res(err_code_t code);
    res_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.err  = code;
    return r;
  endfunction

  function automatic res_t fc_res();
    res_t r;
    logic [7:0] st;
    st = rx_cfg.sep_time;
    // reserved separation times are replaced by the longest millisecond value
    if (st > ST_MAX && !(st >= ST_US_LO && st <= ST_US_HI)) st = ST_MAX;
    r = '0;
    r.kind = KIND_FC;
    r.ctl  = {FC_CTL_HI, rx_cfg.flow_status};
    r.bs   = rx_cfg.block_size;
    r.st   = st;
    return r;
  endfunction

  function automatic void end_message();
    rx_active  = 1'b0;
    seq_want   = 4'd1;
    bytes_left = '0;
    idle_cnt   = '0;
    gap_cnt    = '0;
  endfunction

  // work out the results of one accepted item and queue them
  task automatic receiver_step(input item_t it);
    res_t        batch[$];
    int          n;
    logic [11:0] len;
    if (it.mode) begin
      if (rx_active) begin
        idle_cnt = '0;
        if (gap_cnt != '1) gap_cnt++;
      end else begin
        if (idle_cnt != '1) idle_cnt++;
        if (rx_cfg.idle_timeout != '1 && idle_cnt > rx_cfg.idle_timeout) begin
          batch.push_back(err_res(ERR_IDLE));
          end_message();
        end
      end
    end else if (it.frame_id == rx_cfg.source_id && it.frame_length != '0) begin
      idle_cnt = '0;
      case (it.bytes[0][7:4])
        PCI_SF: begin
          n = (it.bytes[0][3:0] > 4'd7) ? 7 : int'(it.bytes[0][3:0]);
          for (int i = 0; i < n; i++) batch.push_back(pay_res(it.bytes[1+i], 12'(i), 12'(n)));
          batch.push_back(done_res(12'(n)));
          msg_total = 12'(n);
          wr_off    = 12'(n);
          end_message();
        end
        PCI_FF: begin
          len = {it.bytes[0][3:0], it.bytes[1]};
          if (len > 12'd6) begin
            rx_active  = 1'b1;
            seq_want   = 4'd1;
            msg_total  = len;
            bytes_left = len - 12'd6;
            wr_off     = 12'd6;
            blk_left   = rx_cfg.block_size;
            for (int i = 0; i < 6; i++) batch.push_back(pay_res(it.bytes[2+i], 12'(i), len));
            batch.push_back(fc_res());
            gap_cnt = '0;
          end
        end
        PCI_CF: begin
          if (rx_active) begin
            if (gap_cnt > rx_cfg.cf_timeout) begin
              batch.push_back(err_res(ERR_LATE_CF));
              end_message();
            end else if (it.bytes[0][3:0] != seq_want) begin
              batch.push_back(err_res(ERR_SEQ));
              end_message();
            end else begin
              gap_cnt = '0;
              if (bytes_left <= 12'd7) begin
                for (int i = 0; i < int'(bytes_left); i++)
                  batch.push_back(pay_res(it.bytes[1+i], wr_off + 12'(i), msg_total));
                batch.push_back(done_res(msg_total));
                wr_off = wr_off + 12'd7;
                end_message();
              end else begin
                for (int i = 0; i < 7; i++)
                  batch.push_back(pay_res(it.bytes[1+i], wr_off + 12'(i), msg_total));
                bytes_left = bytes_left - 12'd7;
                wr_off     = wr_off + 12'd7;
                seq_want   = seq_want + 4'd1;
                if (rx_cfg.block_size != '0) begin
                  // block counter wraps when it was already zero
                  blk_left = blk_left - 8'd1;
                  if (blk_left == '0) begin
                    blk_left = rx_cfg.block_size;
                    batch.push_back(fc_res());
                    gap_cnt = '0;
                  end
                end
              end
            end
          end
        end
        PCI_FC: ;
        default: begin
          batch.push_back(err_res(ERR_TYPE));
          end_message();
        end
      endcase
    end
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) rx_results_due.push_back(batch[k]);
    results_owed += batch.size();
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        receiver_step(offered);
        if (offered.mode) ticks_sent++;
        else frames_sent++;
      end
      if (!in_valid || !in_stall) begin
        go_now = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (frame_backlog.size() != 0 &&
                     (!frame_backlog[0].drain || results_owed == results_taken)) begin
          next_up = frame_backlog.pop_front();
          offered = next_up.frame;
          go_now  = 1'b1;
          in_mode         <= offered.mode;
          in_frame_id     <= offered.frame_id;
          in_frame_length <= offered.frame_length;
          in_byte_0 <= offered.bytes[0];
          in_byte_1 <= offered.bytes[1];
          in_byte_2 <= offered.bytes[2];
          in_byte_3 <= offered.bytes[3];
          in_byte_4 <= offered.bytes[4];
          in_byte_5 <= offered.bytes[5];
          in_byte_6 <= offered.bytes[6];
          in_byte_7 <= offered.bytes[7];
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= go_now;
      end
    end
  end

  // ---------------- result side ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_cnt = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (style_cnt == 0) begin
        stall_style = $urandom_range(0, 3);
        style_cnt   = $urandom_range(20, 80);
      end else begin
        style_cnt--;
      end
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rx_results_due.size() == 0) begin
        $error("result_kind %0d arrived with nothing expected", out_result_kind);
        fail_count++;
      end else begin
        front_res = rx_results_due.pop_front();
        check_field("result_kind", front_res.kind, out_result_kind);
        check_field("data_byte", front_res.data, out_data_byte);
        check_field("byte_offset", front_res.off, out_byte_offset);
        check_field("message_length", front_res.len, out_message_length);
        check_field("fc_control", front_res.ctl, out_fc_control);
        check_field("fc_block_size", front_res.bs, out_fc_block_size);
        check_field("fc_sep_time", front_res.st, out_fc_sep_time);
        check_field("fault_code", front_res.err, out_fault_code);
        check_field("last", front_res.last, out_last);
        kind_count[front_res.kind]++;
        results_taken <= results_taken + 1;
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic item_t rand_frame(logic [28:0] id, logic [7:0] pci);
    item_t f;
    f.mode         = 1'b0;
    f.frame_id     = id;
    f.frame_length = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd8;
    for (int i = 0; i < FRAME_BYTES; i++) f.bytes[i] = 8'($urandom);
    f.bytes[0] = pci;
    return f;
  endfunction

  task automatic queue_item(input item_t f);
    backlog_t b;
    b.frame = f;
    b.drain = pause_next;
    pause_next = 1'b0;
    frame_backlog.push_back(b);
    queued_count++;
  endtask

  task automatic queue_ticks(input int n);
    item_t f;
    for (int i = 0; i < n; i++) begin
      f = rand_frame(29'($urandom), 8'($urandom));
      f.mode = 1'b1;
      queue_item(f);
    end
  endtask

  task automatic queue_sf(input int nib);
    queue_item(rand_frame(rx_cfg.source_id, {PCI_SF, 4'(nib)}));
  endtask

  task automatic queue_ff(input int len);
    item_t f;
    f = rand_frame(rx_cfg.source_id, {PCI_FF, 4'(len >> 8)});
    f.bytes[1] = 8'(len);
    queue_item(f);
  endtask

  task automatic queue_cf(input int seq);
    queue_item(rand_frame(rx_cfg.source_id, {PCI_CF, 4'(seq)}));
  endtask

  task automatic queue_message(input int len, input int max_gap);
    queue_ff(len);
    for (int k = 1; k <= (len - 6 + 6) / 7; k++) begin
      if (max_gap > 0 && $urandom_range(0, 1) == 1) queue_ticks($urandom_range(1, max_gap));
      queue_cf(k);
    end
  endtask

  // a reassembly that never completes normally
  task automatic queue_broken();
    int n_cf;
    n_cf = $urandom_range(0, 2);
    queue_ff($urandom_range(21, 60));
    for (int k = 1; k <= n_cf; k++) queue_cf(k);
    case ($urandom_range(0, 4))
      0: queue_cf(n_cf + 1 + $urandom_range(1, 15));
      1: queue_sf($urandom_range(0, 15));
      2: queue_ff($urandom_range(0, 4095));
      3: queue_item(rand_frame(rx_cfg.source_id, {4'($urandom_range(4, 15)), 4'($urandom)}));
      default: begin
        queue_ticks($urandom_range(1, 8));
        queue_cf(n_cf + 1);
      end
    endcase
  endtask

  task automatic queue_noise();
    item_t       f;
    logic [28:0] bad_id;
    case ($urandom_range(0, 5))
      0: begin
        bad_id = 29'($urandom);
        if (bad_id == rx_cfg.source_id) bad_id = bad_id ^ 29'd1;
        f = rand_frame(bad_id, 8'($urandom));
      end
      1: begin
        f = rand_frame(rx_cfg.source_id, 8'($urandom));
        f.frame_length = '0;
      end
      2: f = rand_frame(rx_cfg.source_id, {PCI_FC, 4'($urandom)});
      3: f = rand_frame(rx_cfg.source_id, {4'($urandom_range(4, 15)), 4'($urandom)});
      4: f = rand_frame(rx_cfg.source_id, {PCI_CF, 4'($urandom)});
      default: f = rand_frame(rx_cfg.source_id, 8'($urandom));
    endcase
    queue_item(f);
  endtask

  task automatic random_traffic(input int n, input int max_gap, input int tick_run);
    int start, pick;
    bit paused;
    start  = queued_count;
    paused = 1'b0;
    while (queued_count - start < n) begin
      // once per phase, hold the sender until every result is back
      if (!paused && queued_count - start >= n / 2) begin
        pause_next = 1'b1;
        paused     = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35)
        queue_message(($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                  : $urandom_range(7, 40), max_gap);
      else if (pick < 50) queue_sf($urandom_range(0, 15));
      else if (pick < 62) queue_broken();
      else if (pick < 72) queue_ticks($urandom_range(1, tick_run));
      else queue_noise();
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SOURCE_ID:    rx_cfg.source_id    = val[28:0];
      CFG_BLOCK_SIZE:   rx_cfg.block_size   = val[7:0];
      CFG_FLOW_STATUS:  rx_cfg.flow_status  = val[3:0];
      CFG_SEP_TIME:     rx_cfg.sep_time     = val[7:0];
      CFG_CF_TIMEOUT:   rx_cfg.cf_timeout   = val;
      CFG_IDLE_TIMEOUT: rx_cfg.idle_timeout = val;
      default: ;
    endcase
  endtask

  // wait for the backlog to empty and every result to arrive, then let the
  // pipeline run dry of items that produce nothing
  task automatic settle();
    @(negedge clk);
    while (frame_backlog.size() != 0 || in_valid || results_owed != results_taken)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  initial begin
    item_t       f;
    logic [28:0] src;
    logic [7:0]  bsz, st;
    logic [3:0]  fst;
    logic [31:0] cft, idt;
    int          max_gap, tick_run;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset register values
    queue_sf(0);
    f = rand_frame(rx_cfg.source_id, {PCI_SF, 4'd7});
    f.bytes[7:1] = '1;
    queue_item(f);
    f = rand_frame(rx_cfg.source_id, {PCI_SF, 4'hF});
    f.bytes[7:1] = '0;
    queue_item(f);
    queue_item(rand_frame(29'h1FFFFFFF, {PCI_SF, 4'd3}));
    f = rand_frame(rx_cfg.source_id, {PCI_SF, 4'd3});
    f.frame_length = '0;
    queue_item(f);
    queue_ff(6);
    queue_cf(1);
    queue_ff(20);
    queue_cf(1);
    queue_ff(4095);
    queue_cf(2);
    queue_item(rand_frame(rx_cfg.source_id, {PCI_FC, 4'd0}));
    queue_item(rand_frame(rx_cfg.source_id, 8'hF5));
    queue_ff(7);
    queue_ticks(1);
    queue_cf(1);
    settle();

    // block counter starting at zero wraps instead of sending flow control
    write_reg(CFG_BLOCK_SIZE, 32'd0);
    queue_ff(30);
    settle();
    write_reg(CFG_BLOCK_SIZE, 32'd2);
    queue_cf(1);
    queue_cf(2);
    settle();

    // late consecutive frame, then idle timeout
    write_reg(CFG_CF_TIMEOUT, 32'd1);
    write_reg(CFG_IDLE_TIMEOUT, 32'd2);
    queue_ff(15);
    queue_ticks(2);
    queue_cf(1);
    queue_ticks(3);
    settle();

    for (int p = 0; p < 8; p++) begin
      src = 29'($urandom);
      fst = 4'($urandom);
      bsz = 8'($urandom);
      case (p)
        0: begin src = '1; bsz = 8'd0; fst = 4'd0; st = 8'h00; cft = 32'd5; idt = '1;
                 max_gap = 3; tick_run = 6; end
        1: begin src = '0; bsz = 8'd255; fst = 4'hF; st = 8'hFF; cft = 32'd0; idt = 32'd0;
                 max_gap = 1; tick_run = 3; end
        2: begin bsz = 8'd1; st = 8'h80; cft = '1; idt = 32'd4; max_gap = 4; tick_run = 8; end
        3: begin bsz = 8'd2; st = 8'hF0; cft = 32'd3; idt = 32'd10; max_gap = 4;
                 tick_run = 14; end
        4: begin bsz = 8'd3; st = 8'hF1; cft = CF_TIMEOUT_RST; idt = '1; max_gap = 2;
                 tick_run = 6; end
        5: begin st = 8'hF9; cft = 32'd2; idt = 32'd6; max_gap = 3; tick_run = 9; end
        6: begin bsz = 8'd4; st = 8'hFA; cft = 32'd1; idt = 32'd3; max_gap = 2;
                 tick_run = 6; end
        default: begin bsz = 8'd1; st = 8'h7F; cft = '1; idt = '1; max_gap = 2;
                       tick_run = 4; end
      endcase
      // unused upper bits of the write data carry noise
      write_reg(CFG_SOURCE_ID, {3'($urandom), src});
      write_reg(CFG_BLOCK_SIZE, {24'($urandom), bsz});
      write_reg(CFG_FLOW_STATUS, {28'($urandom), fst});
      write_reg(CFG_SEP_TIME, {24'($urandom), st});
      write_reg(CFG_CF_TIMEOUT, cft);
      write_reg(CFG_IDLE_TIMEOUT, idt);
      @(negedge clk);
      random_traffic(43, max_gap, tick_run);
      // long receiver hold-off so the input side backs up
      if (p == 0 || p == 4) hold_req++;
      settle();
    end

    if (rx_results_due.size() != 0) begin
      $error("%0d expected results never arrived", rx_results_due.size());
      fail_count++;
    end
    $display("Sent %0d frames and %0d ticks over 8 register settings plus a directed part.",
             frames_sent, ticks_sent);
    $display("Checked %0d data bytes, %0d flow-control frames, %0d completions, %0d errors.",
             kind_count[KIND_DATA], kind_count[KIND_FC], kind_count[KIND_DONE],
             kind_count[KIND_ERR]);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sfr_pkg.sv
src/sfr_step.sv
src/sfr_emit.sv
src/segmented_frame_receiver.sv
test/segmented_frame_receiver_test.sv
